@@ rtl/cpu8_alu_with_flags_assert.svh @@
// Assertion macros shared by the ALU RTL; clocked on clk, disabled while rst_n is low.
`ifndef CPU8_ALU_WITH_FLAGS_ASSERT_SVH
`define CPU8_ALU_WITH_FLAGS_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CPU8ALU_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cpu8alu: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define CPU8ALU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cpu8alu: next-cycle check failed");

`endif

@@ rtl/cpu8alu_pkg.sv @@
// Package: operation codes, flag bit positions, DAA constants, payload types and flag helpers.
package cpu8alu_pkg;

    localparam logic [4:0] OP_ADD  = 5'd0;
    localparam logic [4:0] OP_ADC  = 5'd1;
    localparam logic [4:0] OP_SUB  = 5'd2;
    localparam logic [4:0] OP_SBB  = 5'd3;
    localparam logic [4:0] OP_ANA  = 5'd4;
    localparam logic [4:0] OP_XRA  = 5'd5;
    localparam logic [4:0] OP_ORA  = 5'd6;
    localparam logic [4:0] OP_CMP  = 5'd7;
    localparam logic [4:0] OP_INR  = 5'd8;
    localparam logic [4:0] OP_DCR  = 5'd9;
    localparam logic [4:0] OP_RLC  = 5'd10;
    localparam logic [4:0] OP_RRC  = 5'd11;
    localparam logic [4:0] OP_RAL  = 5'd12;
    localparam logic [4:0] OP_RAR  = 5'd13;
    localparam logic [4:0] OP_DAA  = 5'd14;
    localparam logic [4:0] OP_CMA  = 5'd15;
    localparam logic [4:0] OP_STC  = 5'd16;
    localparam logic [4:0] OP_CMC  = 5'd17;
    localparam logic [4:0] OP_SRLC = 5'd18;
    localparam logic [4:0] OP_SRRC = 5'd19;
    localparam logic [4:0] OP_SRL  = 5'd20;
    localparam logic [4:0] OP_SRR  = 5'd21;
    localparam logic [4:0] OP_SLA  = 5'd22;
    localparam logic [4:0] OP_SRA  = 5'd23;
    localparam logic [4:0] OP_SLL  = 5'd24;
    localparam logic [4:0] OP_SRLG = 5'd25;
    localparam logic [4:0] OP_BIT  = 5'd26;
    localparam logic [4:0] OP_RES  = 5'd27;
    localparam logic [4:0] OP_SET  = 5'd28;
    localparam logic [4:0] OP_NEG  = 5'd29;

    localparam int FL_S_POS   = 7;
    localparam int FL_Z_POS   = 6;
    localparam int FL_AC_POS  = 4;
    localparam int FL_P_POS   = 2;
    localparam int FL_ONE_POS = 1;
    localparam int FL_CY_POS  = 0;

    localparam logic [7:0] DAA_LOW_ADJ  = 8'h06;
    localparam logic [7:0] DAA_HIGH_ADJ = 8'h60;
    localparam logic [7:0] DAA_HIGH_LIM = 8'h99;
    localparam logic [3:0] DAA_LOW_LIM  = 4'h9;

    typedef struct packed {
        logic [4:0] operation;
        logic [7:0] acc_in;
        logic [7:0] operand;
        logic [7:0] flags_in;
        logic [2:0] bit_index;
    } item_t;

    typedef struct packed {
        logic [7:0] result;
        logic [7:0] flags_out;
        logic       writes_dest;
    } result_t;

    // Sign, zero and even parity of a byte, placed at their flag positions.
    function automatic logic [7:0] szp_of(input logic [7:0] r);
        logic [7:0] f;
        f = 8'h00;
        f[FL_S_POS] = r[7];
        f[FL_Z_POS] = (r == 8'h00);
        f[FL_P_POS] = ~^r;
        return f;
    endfunction

    // Bit 1 reads one, bits 5 and 3 read zero.
    function automatic logic [7:0] fix_flags(input logic [7:0] f);
        logic [7:0] g;
        g = f;
        g[FL_ONE_POS] = 1'b1;
        g[5] = 1'b0;
        g[3] = 1'b0;
        return g;
    endfunction

endpackage

@@ rtl/cpu8alu_if.sv @@
// Valid/ready channel interfaces for ALU items and ALU results.
interface cpu8alu_in_if import cpu8alu_pkg::*; ();
    logic  valid;
    logic  ready;
    item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface cpu8alu_out_if import cpu8alu_pkg::*; ();
    logic    valid;
    logic    ready;
    result_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ rtl/cpu8alu_core.sv @@
// Combinational ALU datapath: shared adder, logic ops, rotates and shifts, DAA, bit group, flags.
module cpu8alu_core import cpu8alu_pkg::*; (
    input  item_t   item,
    output result_t res
);

    logic [7:0] a;
    logic [7:0] v;
    logic [7:0] fi;
    logic       ci;
    logic [7:0] mask;

    logic [7:0] add_a;
    logic [7:0] add_b;
    logic       add_c;
    logic       add_sub;
    logic [8:0] sum9;
    logic [7:0] sum8;
    logic       add_cy;
    logic       add_ac;
    logic [7:0] arith_f;

    logic       daa_lo;
    logic       daa_hi;
    logic [7:0] daa_add;
    logic [7:0] daa_r;
    logic [4:0] daa_nib;

    logic [7:0] r;
    logic [7:0] f;
    logic       wr;

    assign a    = item.acc_in;
    assign v    = item.operand;
    assign fi   = item.flags_in;
    assign ci   = item.flags_in[FL_CY_POS];
    assign mask = 8'h01 << item.bit_index;

    // Operand selection for the one shared adder/subtractor.
    always_comb
    begin
        add_a   = a;
        add_b   = v;
        add_c   = 1'b0;
        add_sub = 1'b0;
        case (item.operation) inside
            OP_ADC:
            begin
                add_c = ci;
            end
            OP_SUB, OP_CMP:
            begin
                add_sub = 1'b1;
            end
            OP_SBB:
            begin
                add_c   = ci;
                add_sub = 1'b1;
            end
            OP_INR:
            begin
                add_a = v;
                add_b = 8'h01;
            end
            OP_DCR:
            begin
                add_a   = v;
                add_b   = 8'h01;
                add_sub = 1'b1;
            end
            OP_NEG:
            begin
                add_a   = 8'h00;
                add_b   = a;
                add_sub = 1'b1;
            end
            default:
            begin
                add_a = a;
            end
        endcase
    end

    // a - b - c is a + ~b + !c; borrow is the inverted carry out.
    assign sum9   = {1'b0, add_a} + {1'b0, (add_sub ? ~add_b : add_b)}
                  + {8'h00, add_c ^ add_sub};
    assign sum8   = sum9[7:0];
    assign add_cy = sum9[8] ^ add_sub;
    assign add_ac = ((add_a[4] ^ add_b[4] ^ sum8[4])) ^ add_sub;

    always_comb
    begin
        arith_f = szp_of(sum8);
        arith_f[FL_AC_POS] = add_ac;
        arith_f[FL_CY_POS] = add_cy;
    end

    assign daa_lo  = (a[3:0] > DAA_LOW_LIM) || fi[FL_AC_POS];
    assign daa_hi  = (a > DAA_HIGH_LIM) || ci;
    assign daa_add = (daa_lo ? DAA_LOW_ADJ : 8'h00) | (daa_hi ? DAA_HIGH_ADJ : 8'h00);
    assign daa_r   = a + daa_add;
    assign daa_nib = {1'b0, a[3:0]} + {1'b0, daa_add[3:0]};

    always_comb
    begin
        r  = a;
        f  = fi;
        wr = 1'b1;
        unique case (item.operation) inside
            OP_ADD, OP_ADC, OP_SUB, OP_SBB, OP_NEG:
            begin
                r = sum8;
                f = arith_f;
            end
            OP_CMP:
            begin
                f  = arith_f;
                wr = 1'b0;
            end
            OP_INR, OP_DCR:
            begin
                r = sum8;
                f = arith_f;
                f[FL_CY_POS] = ci;
            end
            OP_ANA:
            begin
                r = a & v;
                f = szp_of(a & v);
                f[FL_AC_POS] = a[3] | v[3];
            end
            OP_XRA:
            begin
                r = a ^ v;
                f = szp_of(a ^ v);
            end
            OP_ORA:
            begin
                r = a | v;
                f = szp_of(a | v);
            end
            OP_RLC:
            begin
                r = {a[6:0], a[7]};
                f[FL_CY_POS] = a[7];
            end
            OP_RRC:
            begin
                r = {a[0], a[7:1]};
                f[FL_CY_POS] = a[0];
            end
            OP_RAL:
            begin
                r = {a[6:0], ci};
                f[FL_CY_POS] = a[7];
            end
            OP_RAR:
            begin
                r = {ci, a[7:1]};
                f[FL_CY_POS] = a[0];
            end
            OP_DAA:
            begin
                r = daa_r;
                f = szp_of(daa_r);
                f[FL_AC_POS] = daa_nib[4];
                f[FL_CY_POS] = daa_hi;
            end
            OP_CMA:
            begin
                r = ~a;
            end
            OP_STC:
            begin
                f[FL_CY_POS] = 1'b1;
                wr = 1'b0;
            end
            OP_CMC:
            begin
                f[FL_CY_POS] = ~ci;
                wr = 1'b0;
            end
            OP_SRLC:
            begin
                r = {v[6:0], v[7]};
                f = szp_of(r);
                f[FL_CY_POS] = v[7];
            end
            OP_SRRC:
            begin
                r = {v[0], v[7:1]};
                f = szp_of(r);
                f[FL_CY_POS] = v[0];
            end
            OP_SRL:
            begin
                r = {v[6:0], ci};
                f = szp_of(r);
                f[FL_CY_POS] = v[7];
            end
            OP_SRR:
            begin
                r = {ci, v[7:1]};
                f = szp_of(r);
                f[FL_CY_POS] = v[0];
            end
            OP_SLA:
            begin
                r = {v[6:0], 1'b0};
                f = szp_of(r);
                f[FL_CY_POS] = v[7];
            end
            OP_SRA:
            begin
                r = {v[7], v[7:1]};
                f = szp_of(r);
                f[FL_CY_POS] = v[0];
            end
            OP_SLL:
            begin
                r = {v[6:0], 1'b1};
                f = szp_of(r);
                f[FL_CY_POS] = v[7];
            end
            OP_SRLG:
            begin
                r = {1'b0, v[7:1]};
                f = szp_of(r);
                f[FL_CY_POS] = v[0];
            end
            OP_BIT:
            begin
                r = v;
                f = szp_of(v & mask);
                f[FL_AC_POS] = 1'b1;
                f[FL_CY_POS] = ci;
                wr = 1'b0;
            end
            OP_RES:
            begin
                r = v & ~mask;
            end
            OP_SET:
            begin
                r = v | mask;
            end
            default:
            begin
                // unused codes: no write, flags pass through
                wr = 1'b0;
            end
        endcase
    end

    assign res.result      = r;
    assign res.flags_out   = fix_flags(f);
    assign res.writes_dest = wr;

endmodule

@@ rtl/cpu8_alu_with_flags.sv @@
// Top level: input register, ALU datapath, result register with valid/ready on both sides.
// 8080-style byte ALU with the extended shift and bit group. One item is accepted per
// cycle while the registers have room. A result passes through two registers: the input
// register is loaded at the accepting edge and the result register once it has room, with
// the single-pass ALU logic between them. Items leave in order. Both stages hold under
// backpressure and the input side keeps taking items while a result waits, as long as one
// of the two registers has room. Flags out always have bit 1 set and bits 5 and 3 clear.
module cpu8_alu_with_flags import cpu8alu_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    cpu8alu_in_if.sink    cmd,
    cpu8alu_out_if.source rsp
);

`include "cpu8_alu_with_flags_assert.svh"

    logic    s1_valid_reg;
    item_t   s1_item_reg;
    logic    s2_valid_reg;
    result_t s2_res_reg;
    logic    s1_ready;
    logic    s2_ready;
    logic    cmd_xfer;
    result_t alu_res;

    assign s2_ready  = !s2_valid_reg || rsp.ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign cmd.ready = s1_ready;
    assign cmd_xfer  = cmd.valid && s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_xfer)
        begin
            s1_item_reg <= cmd.data;
        end
    end

    cpu8alu_core u_core (
        .item (s1_item_reg),
        .res  (alu_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            s2_res_reg <= alu_res;
        end
    end

    assign rsp.valid = s2_valid_reg;
    assign rsp.data  = s2_res_reg;

    `CPU8ALU_ASSERT_NOW(a_fixed_flag_bits, rsp.valid, rsp.data.flags_out[FL_ONE_POS] && !rsp.data.flags_out[5] && !rsp.data.flags_out[3])
    `CPU8ALU_ASSERT_NEXT(a_in_lands_in_s1, cmd_xfer, s1_valid_reg)
    `CPU8ALU_ASSERT_NEXT(a_s1_holds_on_stall, s1_valid_reg && !s2_ready, s1_valid_reg && $stable(s1_item_reg))
    `CPU8ALU_ASSERT_NEXT(a_s1_moves_to_s2, s1_valid_reg && s2_ready, rsp.valid)

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for the 8080-style byte ALU: directed sweep, random traffic, flag prediction.
`timescale 1ns / 1ps

module tb_top import cpu8alu_pkg::*; ();

    localparam logic [4:0] OP_SPARE_A = 5'd30;   // unused codes: no write, flags pass through
    localparam logic [4:0] OP_SPARE_B = 5'd31;
    localparam int RANDOM_ITEMS   = 950;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 8;
    localparam int REPORT_LIMIT   = 10;

    typedef struct {
        item_t   src;
        result_t want;
    } alu_due_t;

    class alu_result_board;
        alu_due_t results_due[$];
        int       mismatches;

        function new();
            mismatches = 0;
        endfunction

        function logic [7:0] szp(input logic [7:0] r);
            logic [7:0] f;
            f = 8'h00;
            f[FL_S_POS] = r[7];
            f[FL_Z_POS] = (r == 8'h00);
            f[FL_P_POS] = ~^r;
            return f;
        endfunction

        function logic [7:0] sum_flags(input logic [7:0] x, input logic [7:0] y,
                                       input logic c, output logic [7:0] r);
            logic [8:0] s;
            logic [7:0] f;
            s = {1'b0, x} + {1'b0, y} + {8'h00, c};
            r = s[7:0];
            f = szp(r);
            f[FL_CY_POS] = s[8];
            f[FL_AC_POS] = x[4] ^ y[4] ^ r[4];
            return f;
        endfunction

        // AC reads as "no borrow out of bit 3"
        function logic [7:0] diff_flags(input logic [7:0] x, input logic [7:0] y,
                                        input logic c, output logic [7:0] r);
            logic [8:0] d;
            logic [7:0] f;
            d = {1'b0, x} - {1'b0, y} - {8'h00, c};
            r = d[7:0];
            f = szp(r);
            f[FL_CY_POS] = d[8];
            f[FL_AC_POS] = ~(x[4] ^ y[4] ^ r[4]);
            return f;
        endfunction

        function result_t alu_outcome(input item_t it);
            logic [7:0] a, v, fi, r, f, adj, scratch;
            logic       ci, cy, wr;
            logic [4:0] low_sum;
            result_t    o;
            a  = it.acc_in;
            v  = it.operand;
            fi = it.flags_in;
            ci = fi[FL_CY_POS];
            r  = a;
            f  = fi;
            wr = 1'b1;
            cy = 1'b0;
            case (it.operation)
                OP_ADD: f = sum_flags(a, v, 1'b0, r);
                OP_ADC: f = sum_flags(a, v, ci, r);
                OP_SUB: f = diff_flags(a, v, 1'b0, r);
                OP_SBB: f = diff_flags(a, v, ci, r);
                OP_ANA:
                begin
                    r = a & v;
                    f = szp(r);
                    f[FL_AC_POS] = a[3] | v[3];
                end
                OP_XRA:
                begin
                    r = a ^ v;
                    f = szp(r);
                end
                OP_ORA:
                begin
                    r = a | v;
                    f = szp(r);
                end
                OP_CMP:
                begin
                    f  = diff_flags(a, v, 1'b0, scratch);
                    wr = 1'b0;
                end
                OP_INR:
                begin
                    f = sum_flags(v, 8'h01, 1'b0, r);
                    f[FL_CY_POS] = ci;
                end
                OP_DCR:
                begin
                    f = diff_flags(v, 8'h01, 1'b0, r);
                    f[FL_CY_POS] = ci;
                end
                OP_RLC:
                begin
                    r = {a[6:0], a[7]};
                    f[FL_CY_POS] = a[7];
                end
                OP_RRC:
                begin
                    r = {a[0], a[7:1]};
                    f[FL_CY_POS] = a[0];
                end
                OP_RAL:
                begin
                    r = {a[6:0], ci};
                    f[FL_CY_POS] = a[7];
                end
                OP_RAR:
                begin
                    r = {ci, a[7:1]};
                    f[FL_CY_POS] = a[0];
                end
                OP_DAA:
                begin
                    adj = 8'h00;
                    cy  = ci;
                    if (a[3:0] > DAA_LOW_LIM || fi[FL_AC_POS])
                        adj = adj | DAA_LOW_ADJ;
                    if (a > DAA_HIGH_LIM || cy)
                    begin
                        adj = adj | DAA_HIGH_ADJ;
                        cy  = 1'b1;
                    end
                    r = a + adj;
                    low_sum = {1'b0, a[3:0]} + {1'b0, adj[3:0]};
                    f = szp(r);
                    f[FL_CY_POS] = cy;
                    f[FL_AC_POS] = low_sum[4];
                end
                OP_CMA: r = ~a;
                OP_STC:
                begin
                    f[FL_CY_POS] = 1'b1;
                    wr = 1'b0;
                end
                OP_CMC:
                begin
                    f[FL_CY_POS] = ~ci;
                    wr = 1'b0;
                end
                OP_SRLC:
                begin
                    cy = v[7];
                    r  = {v[6:0], v[7]};
                end
                OP_SRRC:
                begin
                    cy = v[0];
                    r  = {v[0], v[7:1]};
                end
                OP_SRL:
                begin
                    cy = v[7];
                    r  = {v[6:0], ci};
                end
                OP_SRR:
                begin
                    cy = v[0];
                    r  = {ci, v[7:1]};
                end
                OP_SLA:
                begin
                    cy = v[7];
                    r  = {v[6:0], 1'b0};
                end
                OP_SRA:
                begin
                    cy = v[0];
                    r  = {v[7], v[7:1]};
                end
                OP_SLL:
                begin
                    cy = v[7];
                    r  = {v[6:0], 1'b1};
                end
                OP_SRLG:
                begin
                    cy = v[0];
                    r  = {1'b0, v[7:1]};
                end
                OP_BIT:
                begin
                    f = szp(v & (8'h01 << it.bit_index));
                    f[FL_AC_POS] = 1'b1;
                    f[FL_CY_POS] = ci;
                    r  = v;
                    wr = 1'b0;
                end
                OP_RES: r = v & ~(8'h01 << it.bit_index);
                OP_SET: r = v | (8'h01 << it.bit_index);
                OP_NEG: f = diff_flags(8'h00, a, 1'b0, r);
                default: wr = 1'b0;
            endcase
            if (it.operation >= OP_SRLC && it.operation <= OP_SRLG)
            begin
                f = szp(r);
                f[FL_CY_POS] = cy;
            end
            // bit 1 always one, bits 5 and 3 always zero
            f[FL_ONE_POS] = 1'b1;
            f[5] = 1'b0;
            f[3] = 1'b0;
            o.result      = r;
            o.flags_out   = f;
            o.writes_dest = wr;
            return o;
        endfunction

        function void note_input(input item_t it);
            alu_due_t d;
            d.src  = it;
            d.want = alu_outcome(it);
            results_due.push_back(d);
        endfunction

        function void check_result(input result_t got);
            alu_due_t d;
            if (results_due.size() == 0)
            begin
                if (mismatches < REPORT_LIMIT)
                    $display("unexpected result %h flags %h wr %b, nothing pending",
                             got.result, got.flags_out, got.writes_dest);
                mismatches++;
                return;
            end
            d = results_due.pop_front();
            if (got.result !== d.want.result || got.flags_out !== d.want.flags_out
                || got.writes_dest !== d.want.writes_dest)
            begin
                if (mismatches < REPORT_LIMIT)
                    $display("mismatch op %0d a %h v %h f %h b %0d: want %h/%h/%b got %h/%h/%b",
                             d.src.operation, d.src.acc_in, d.src.operand, d.src.flags_in,
                             d.src.bit_index, d.want.result, d.want.flags_out,
                             d.want.writes_dest, got.result, got.flags_out, got.writes_dest);
                mismatches++;
            end
        endfunction

        function int pending();
            return results_due.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   idle_cycles = 0;
    alu_result_board board;

    cpu8alu_in_if  cmd ();
    cpu8alu_out_if rsp ();

    cpu8_alu_with_flags dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .rsp   (rsp)
    );

    always #1 clk = ~clk;

    // mostly back-to-back, some short gaps, a few long ones
    function automatic int pick_gap(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 9))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h80;
            3: return 8'h7F;
            4: return {4'($urandom_range(0, 9)), 4'($urandom_range(0, 15))};
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic item_t random_item();
        item_t it;
        int    pick;
        pick = $urandom_range(0, 99);
        if (pick < 3)
            it.operation = pick[0] ? OP_SPARE_A : OP_SPARE_B;
        else
            it.operation = 5'($urandom_range(OP_ADD, OP_NEG));
        it.acc_in    = pick_byte();
        it.operand   = pick_byte();
        it.flags_in  = pick_byte();
        it.bit_index = 3'($urandom_range(0, 7));
        return it;
    endfunction

    task automatic drive_item(input item_t it, input bit calm);
        int gap;
        cmd.data  <= it;
        cmd.valid <= 1'b1;
        @(posedge clk);
        while (!cmd.ready)
            @(posedge clk);
        board.note_input(it);
        gap = pick_gap(calm);
        if (gap > 0)
        begin
            cmd.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // result side: ready runs of random length, long runs now and then
    initial
    begin
        int run;
        int stall;
        rsp.ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                              : $urandom_range(1, 12);
            rsp.ready <= 1'b1;
            repeat (run) @(posedge clk);
            stall = pick_gap(1'b0);
            if (stall > 0)
            begin
                rsp.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp.valid && rsp.ready)
            board.check_result(rsp.data);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (cmd.valid && cmd.ready) || (rsp.valid && rsp.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        item_t it;
        bit    calm;
        board = new();
        cmd.valid <= 1'b0;
        cmd.data  <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every code once at the byte extremes, with the interesting corners patched in
        for (int k = 0; k <= OP_SPARE_B; k++)
        begin
            it.operation = k[4:0];
            it.acc_in    = (k % 3 == 0) ? 8'h00 : ((k % 3 == 1) ? 8'hFF : 8'h80);
            it.operand   = k[0] ? 8'h01 : 8'hFF;
            it.flags_in  = k[1] ? 8'hFF : 8'h00;
            it.bit_index = k[2:0];
            case (it.operation)
                OP_ADC:
                begin
                    it.acc_in   = 8'hFF;
                    it.operand  = 8'h00;
                    it.flags_in = 8'h01;
                end
                OP_SUB:
                begin
                    it.acc_in  = 8'h10;   // borrow out of bit 3
                    it.operand = 8'h01;
                end
                OP_CMP:
                begin
                    it.acc_in  = 8'h42;
                    it.operand = 8'h42;
                end
                OP_INR: it.operand = 8'h0F;
                OP_DAA:
                begin
                    it.acc_in   = 8'h9B;  // both nibbles need correction
                    it.flags_in = 8'h00;
                end
                OP_BIT:
                begin
                    it.operand   = 8'h80;
                    it.bit_index = 3'd7;
                    it.flags_in  = 8'h01;
                end
                OP_NEG: it.acc_in = 8'h80;
                default: ;
            endcase
            drive_item(it, 1'b0);
        end
        // decimal adjust driven by the half-carry alone
        it.operation = OP_DAA;
        it.acc_in    = 8'h15;
        it.flags_in  = 8'h10;
        drive_item(it, 1'b0);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS / 2)
            begin
                // let the pipe run dry once before carrying on
                cmd.valid <= 1'b0;
                @(posedge clk);
                while (board.pending() != 0)
                    @(posedge clk);
            end
            calm = ((n / 120) % 3 == 2);
            drive_item(random_item(), calm);
        end
        cmd.valid <= 1'b0;

        @(posedge clk);
        while (board.pending() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (board.mismatches == 0 && board.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/cpu8alu_pkg.sv
rtl/cpu8alu_if.sv
rtl/cpu8alu_core.sv
rtl/cpu8_alu_with_flags.sv
dv/tb_top.sv
